// ----- sv/tournament_branch_predictor_core_assert.svh -----
`ifndef TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbp assertion failed");

// Next-cycle implication, checked outside reset.
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbp assertion failed");

`endif

// ----- sv/tbp_pkg.sv -----
package tbp_pkg;

    localparam int TABLE_ENTRIES_DEF = 2048;
    localparam int MAX_HISTORY_DEF   = 11;
    localparam int ADDR_W            = 32;
    localparam int CNT_W             = 32;
    localparam int CFG_W             = 4;
    localparam int CTR_W             = 2;

    typedef logic [CTR_W-1:0] ctr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd11;
    localparam ctr_t CTR_MAX           = 2'd3;
    localparam ctr_t CTR_MIN           = 2'd0;
    localparam ctr_t CTR_TAKEN_RESET   = 2'd3;
    localparam ctr_t CTR_CHOOSER_RESET = 2'd0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic pred;
        logic use_b;
        logic hit;
        ctr_t g_new;
        ctr_t b_new;
        ctr_t c_new;
    } upd_t;

    // Step a 2-bit counter toward the direction given, saturating at both ends.
    function automatic ctr_t train(ctr_t ctr, logic up);
        ctr_t res;
        if (up)
        begin
            res = (ctr == CTR_MAX) ? ctr : ctr + ctr_t'(1);
        end
        else
        begin
            res = (ctr == CTR_MIN) ? ctr : ctr - ctr_t'(1);
        end
        return res;
    endfunction

    function automatic cnt_t sat_inc(cnt_t v);
        cnt_t res;
        res = (&v) ? v : v + cnt_t'(1);
        return res;
    endfunction

endpackage

// ----- sv/tbp_ram.sv -----
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tbp_update.sv -----
module tbp_update (
    input  tbp_pkg::ctr_t g_ctr,
    input  tbp_pkg::ctr_t b_ctr,
    input  tbp_pkg::ctr_t c_ctr,
    input  logic          taken,
    output tbp_pkg::upd_t upd
);

    import tbp_pkg::*;

    logic g_pred;
    logic b_pred;
    logic g_hit;
    logic b_hit;
    logic use_b;

    always_comb
    begin
        g_pred = g_ctr[CTR_W-1];
        b_pred = b_ctr[CTR_W-1];
        g_hit  = (g_pred == taken);
        b_hit  = (b_pred == taken);
        use_b  = c_ctr[CTR_W-1];

        upd.pred  = use_b ? b_pred : g_pred;
        upd.use_b = use_b;
        upd.hit   = use_b ? b_hit : g_hit;
        upd.g_new = train(g_ctr, taken);
        upd.b_new = train(b_ctr, taken);
        // move the chooser only when the two components disagree on correctness
        upd.c_new = (b_hit != g_hit) ? train(c_ctr, b_hit) : c_ctr;
    end

endmodule

// ----- sv/tournament_branch_predictor_core.sv -----
// Tournament branch predictor (gshare plus bimodal with a chooser). For each
// resolved branch the accept edge launches the read of the gshare memory and
// of the combined bimodal/chooser memory, and the update state then trains the
// counters, writes them back and loads the result register once that register
// is free; the read-modify-write of the counter memories means the block takes
// no new branch until it is through with the last one.
// A result waiting on out_stall does not block the next input transaction,
// which is held only in its update cycle until the result register frees.
// After reset a clearing pass writes every table entry (2048 by default), one
// per cycle, before the first branch is accepted; configuration writes are
// taken at any time. TABLE_ENTRIES must be a power of two.
module tournament_branch_predictor_core #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_HISTORY   = tbp_pkg::MAX_HISTORY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tbp_pkg::ADDR_W-1:0] branch_address,
    input  logic                       branch_taken,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       predicted_taken,
    output logic                       used_bimodal,
    output logic                       prediction_correct,
    output logic [tbp_pkg::CNT_W-1:0]  correct_total,
    output logic [tbp_pkg::CNT_W-1:0]  branch_total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tbp_pkg::CFG_W-1:0]  cfg_data
);

    import tbp_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int HIST_W = MAX_HISTORY;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [CFG_W-1:0]  history_bits_reg, history_bits_next;
    cnt_t              correct_count_reg, correct_count_next;
    cnt_t              branch_count_reg, branch_count_next;
    logic              out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]  g_idx_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic              taken_reg;
    logic              pred_reg;
    logic              use_b_reg;
    logic              hit_reg;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic              clearing;
    logic              clr_done;

    logic [HIST_W-1:0] hist_mask;
    logic [ADDR_W-1:0] g_full;
    logic [IDX_W-1:0]  g_idx;
    logic [IDX_W-1:0]  b_idx;

    logic              g_wr_en;
    logic [IDX_W-1:0]  g_wr_addr;
    ctr_t              g_wr_data;
    ctr_t              g_rd_data;
    logic              bc_wr_en;
    logic [IDX_W-1:0]  bc_wr_addr;
    logic [2*CTR_W-1:0] bc_wr_data;
    logic [2*CTR_W-1:0] bc_rd_data;

    upd_t              upd;

    // Index generation from the incoming branch
    always_comb
    begin
        for (int i = 0; i < HIST_W; i++)
        begin
            // bits at or above MAX_HISTORY never exist, so clamping is implicit
            hist_mask[i] = (int'(history_bits_reg) > i);
        end
        g_full = branch_address ^ ADDR_W'(hist_reg & hist_mask);
        g_idx  = g_full[IDX_W-1:0];
        b_idx  = branch_address[IDX_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall = 1'b1;
        clearing = 1'b0;
        commit   = 1'b0;
        out_free = !out_valid_reg || !out_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        accept   = in_valid && !in_stall;
        clr_done = (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    end

    tbp_update u_update (
        .g_ctr (g_rd_data),
        .b_ctr (bc_rd_data[2*CTR_W-1:CTR_W]),
        .c_ctr (bc_rd_data[CTR_W-1:0]),
        .taken (taken_reg),
        .upd   (upd)
    );

    // Memory write ports: clearing pass or write-back of trained counters
    always_comb
    begin
        g_wr_en    = clearing || commit;
        bc_wr_en   = clearing || commit;
        g_wr_addr  = clearing ? clr_idx_reg : g_idx_reg;
        bc_wr_addr = clearing ? clr_idx_reg : b_idx_reg;
        g_wr_data  = clearing ? CTR_TAKEN_RESET : upd.g_new;
        bc_wr_data = clearing ? {CTR_TAKEN_RESET, CTR_CHOOSER_RESET}
                              : {upd.b_new, upd.c_new};
    end

    tbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_gshare_ram (
        .clk     (clk),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_en   (accept),
        .rd_addr (g_idx),
        .rd_data (g_rd_data)
    );

    tbp_ram #(
        .WIDTH (2 * CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_bimodal_chooser_ram (
        .clk     (clk),
        .wr_en   (bc_wr_en),
        .wr_addr (bc_wr_addr),
        .wr_data (bc_wr_data),
        .rd_en   (accept),
        .rd_addr (b_idx),
        .rd_data (bc_rd_data)
    );

    // Control register next values
    always_comb
    begin
        clr_idx_next       = clearing ? clr_idx_reg + IDX_W'(1) : clr_idx_reg;
        hist_next          = hist_reg;
        correct_count_next = correct_count_reg;
        branch_count_next  = branch_count_reg;
        history_bits_next  = (cfg_valid && cfg_ready) ? cfg_data : history_bits_reg;
        out_valid_next     = out_valid_reg && out_stall;
        if (commit)
        begin
            hist_next          = (hist_reg << 1) | HIST_W'(taken_reg);
            correct_count_next = upd.hit ? sat_inc(correct_count_reg) : correct_count_reg;
            branch_count_next  = sat_inc(branch_count_reg);
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_idx_reg       <= '0;
            hist_reg          <= '0;
            history_bits_reg  <= HISTORY_BITS_RESET;
            correct_count_reg <= '0;
            branch_count_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_idx_reg       <= clr_idx_next;
            hist_reg          <= hist_next;
            history_bits_reg  <= history_bits_next;
            correct_count_reg <= correct_count_next;
            branch_count_reg  <= branch_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g_idx_reg <= g_idx;
            b_idx_reg <= b_idx;
            taken_reg <= branch_taken;
        end
        if (commit)
        begin
            pred_reg  <= upd.pred;
            use_b_reg <= upd.use_b;
            hit_reg   <= upd.hit;
        end
    end

    assign cfg_ready          = 1'b1;
    assign out_valid          = out_valid_reg;
    assign predicted_taken    = pred_reg;
    assign used_bimodal       = use_b_reg;
    assign prediction_correct = hit_reg;
    assign correct_total      = correct_count_reg;
    assign branch_total       = branch_count_reg;

endmodule

// ----- sv/tbp_checker.sv -----
`include "tournament_branch_predictor_core_assert.svh"

module tbp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [tbp_pkg::CNT_W-1:0]  correct_total,
    input logic [tbp_pkg::CNT_W-1:0]  branch_total
);

    // a waiting result holds, totals included
    `TBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(branch_total) && $stable(correct_total))

    // one branch in flight: a transaction is followed by a busy cycle
    `TBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // correct predictions never outnumber branches
    `TBP_ASSERT_IMPL(a_totals_order, clk, rst_n, out_valid, correct_total <= branch_total)

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (.*);
